// ----- rtl/plc_pkg.sv -----
// Shared constants, types and command/status structs of the calibration unit.
package plc_pkg;

  localparam int POINTS_DEF          = 8;
  localparam int SINGLE_CHANNELS_DEF = 4;
  localparam int DIFF_CHANNELS_DEF   = 2;

  localparam int DATA_W   = 32;
  localparam int FUNC_W   = 2;
  localparam int CH_W     = 3;
  localparam int PT_W     = 3;
  localparam int TOTAL_W  = 4;
  localparam int STATUS_W = 3;

  // dividend is the 66-bit product of two 33-bit magnitudes
  localparam int PROD_W    = 66;
  localparam int DIV_STEPS = 66;
  localparam int DIV_CNT_W = 7;

  localparam logic [FUNC_W-1:0] FUNC_STORE   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_COUNT   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CONVERT = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_BAD     = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_PASS   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DEGEN  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_SAT    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_REJECT = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_READ, S_SCAN, S_SETUP,
    S_MUL_LO, S_MUL_HI, S_DIV, S_EMIT
  } plc_state_t;

  typedef enum logic [2:0] {
    RES_ZERO, RES_REJECT, RES_PASS, RES_FIRST, RES_LEFT, RES_CALC
  } res_sel_t;

  typedef struct packed {
    logic     load;
    logic     store_wr;
    logic     count_wr;
    logic     rd_en;
    logic     scan;
    logic     scan_first;
    logic     scan_second;
    logic     pick_hit;
    logic     pick_end;
    logic     setup;
    logic     mul_lo;
    logic     mul_hi;
    logic     div_step;
    logic     out_load;
    res_sel_t res_sel;
  } plc_cmd_t;

  typedef struct packed {
    logic              reject;
    logic [FUNC_W-1:0] func;
    logic              n_zero;
    logic              n_one;
    logic              hit;
    logic              degen;
  } plc_stat_t;

endpackage

// ----- rtl/plc_ifs.sv -----
// Valid/ready channel interfaces for input items and result items.
interface plc_in_if;
  logic                                valid;
  logic                                ready;
  logic [plc_pkg::FUNC_W-1:0]          func;
  logic [plc_pkg::CH_W-1:0]            channel_index;
  logic [plc_pkg::PT_W-1:0]            point_index;
  logic signed [plc_pkg::DATA_W-1:0]   raw_value;
  logic signed [plc_pkg::DATA_W-1:0]   real_value;
  logic [plc_pkg::TOTAL_W-1:0]         point_total;
  logic signed [plc_pkg::DATA_W-1:0]   measured_value;

  modport source (output valid, func, channel_index, point_index, raw_value, real_value,
                  point_total, measured_value, input ready);
  modport sink   (input valid, func, channel_index, point_index, raw_value, real_value,
                  point_total, measured_value, output ready);
endinterface

interface plc_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [plc_pkg::DATA_W-1:0]   corrected_value;
  logic [plc_pkg::STATUS_W-1:0]        status;

  modport source (output valid, corrected_value, status, input ready);
  modport sink   (input valid, corrected_value, status, output ready);
endinterface

// ----- rtl/plc_datapath.sv -----
// Datapath: point memories, counts, segment search registers, multiplier and divider.
module plc_datapath #(
  parameter int POINTS   = plc_pkg::POINTS_DEF,
  parameter int CHANNELS = plc_pkg::SINGLE_CHANNELS_DEF + plc_pkg::DIFF_CHANNELS_DEF,
  localparam int DEPTH   = CHANNELS * POINTS,
  localparam int AW      = $clog2(DEPTH),
  localparam int CIW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
  localparam int PIW     = $clog2(POINTS),
  localparam int NW      = $clog2(POINTS + 1)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  plc_pkg::plc_cmd_t                   cmd,
  input  logic [PIW-1:0]                      rd_idx,
  output plc_pkg::plc_stat_t                  stat,
  output logic [NW-1:0]                       n_pts,
  input  logic [plc_pkg::FUNC_W-1:0]          func,
  input  logic [plc_pkg::CH_W-1:0]            channel_index,
  input  logic [plc_pkg::PT_W-1:0]            point_index,
  input  logic signed [plc_pkg::DATA_W-1:0]   raw_value,
  input  logic signed [plc_pkg::DATA_W-1:0]   real_value,
  input  logic [plc_pkg::TOTAL_W-1:0]         point_total,
  input  logic signed [plc_pkg::DATA_W-1:0]   measured_value,
  output logic signed [plc_pkg::DATA_W-1:0]   corrected_value,
  output logic [plc_pkg::STATUS_W-1:0]        status
);

  logic [plc_pkg::FUNC_W-1:0]   func_r;
  logic [plc_pkg::CH_W-1:0]     ch_r;
  logic [plc_pkg::PT_W-1:0]     pt_r;
  logic signed [31:0]           raw_r, real_r, m_r;
  logic [plc_pkg::TOTAL_W-1:0]  total_r;

  logic [NW-1:0]  count_r [CHANNELS];
  logic [31:0]    raw_mem  [DEPTH];
  logic [31:0]    real_mem [DEPTH];
  logic signed [31:0] raw_q, real_q;

  logic signed [31:0] prev_x_r, prev_y_r, x0_r, y0_r, x1_r, y1_r;
  logic signed [31:0] sx0_r, sy0_r, sx1_r, sy1_r, bx_r, by_r;
  logic [32:0]        a_r, b_r, d_r;
  logic               neg_r;
  logic [plc_pkg::PROD_W-1:0] p_r;
  logic [32:0]        rem_r;

  logic [CIW-1:0] ch_idx;
  logic [AW-1:0]  waddr, raddr;

  assign ch_idx = CIW'(ch_r);
  assign waddr  = AW'(int'(ch_idx) * POINTS + int'(pt_r));
  assign raddr  = AW'(int'(ch_idx) * POINTS + int'(rd_idx));
  assign n_pts  = count_r[ch_idx];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r  <= func;
      ch_r    <= channel_index;
      pt_r    <= point_index;
      raw_r   <= raw_value;
      real_r  <= real_value;
      total_r <= point_total;
      m_r     <= measured_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) count_r[i] <= '0;
    end else if (cmd.count_wr) begin
      count_r[ch_idx] <= NW'(total_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store_wr) begin
      raw_mem[waddr]  <= raw_r;
      real_mem[waddr] <= real_r;
    end
    if (cmd.rd_en) begin
      raw_q  <= raw_mem[raddr];
      real_q <= real_mem[raddr];
    end
  end

  // decode and search status
  always_comb begin
    stat.reject = (int'(ch_r) >= CHANNELS) || (func_r == plc_pkg::FUNC_BAD) ||
                  ((func_r == plc_pkg::FUNC_STORE) && (int'(pt_r) >= POINTS)) ||
                  ((func_r == plc_pkg::FUNC_COUNT) && (int'(total_r) > POINTS));
    stat.func   = func_r;
    stat.n_zero = (n_pts == '0);
    stat.n_one  = (n_pts == NW'(1));
    stat.hit    = (m_r >= prev_x_r) && (m_r <= raw_q);
    stat.degen  = (sx1_r == sx0_r);
  end

  logic signed [31:0] x1_eff, y1_eff;
  assign x1_eff = cmd.scan_second ? raw_q  : x1_r;
  assign y1_eff = cmd.scan_second ? real_q : y1_r;

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      prev_x_r <= raw_q;
      prev_y_r <= real_q;
      if (cmd.scan_first) begin
        x0_r <= raw_q;
        y0_r <= real_q;
      end
      if (cmd.scan_second) begin
        x1_r <= raw_q;
        y1_r <= real_q;
      end
    end
    if (cmd.pick_hit) begin
      sx0_r <= prev_x_r; sy0_r <= prev_y_r;
      sx1_r <= raw_q;    sy1_r <= real_q;
      bx_r  <= prev_x_r; by_r  <= prev_y_r;
    end else if (cmd.pick_end) begin
      if (m_r < x0_r) begin
        // below the first point: extend the first segment from its left end
        sx0_r <= x0_r;   sy0_r <= y0_r;
        sx1_r <= x1_eff; sy1_r <= y1_eff;
        bx_r  <= x0_r;   by_r  <= y0_r;
      end else begin
        // above: extend the last segment from its right end
        sx0_r <= prev_x_r; sy0_r <= prev_y_r;
        sx1_r <= raw_q;    sy1_r <= real_q;
        bx_r  <= raw_q;    by_r  <= real_q;
      end
    end
  end

  // magnitudes and sign of (m - bx) * (y1 - y0) / (x1 - x0)
  logic signed [32:0] dx, dy, dd;
  assign dx = {m_r[31], m_r} - {bx_r[31], bx_r};
  assign dy = {sy1_r[31], sy1_r} - {sy0_r[31], sy0_r};
  assign dd = {sx1_r[31], sx1_r} - {sx0_r[31], sx0_r};

  logic [49:0] pp_lo;
  logic [48:0] pp_hi;
  logic [33:0] sh;
  logic        ge;
  assign pp_lo = a_r * b_r[16:0];
  assign pp_hi = a_r * b_r[32:17];
  assign sh    = {rem_r, p_r[plc_pkg::PROD_W-1]};
  assign ge    = sh >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      a_r   <= dx[32] ? 33'(-dx) : 33'(dx);
      b_r   <= dy[32] ? 33'(-dy) : 33'(dy);
      d_r   <= dd[32] ? 33'(-dd) : 33'(dd);
      neg_r <= dx[32] ^ dy[32] ^ dd[32];
    end
    if (cmd.mul_lo) begin
      p_r <= plc_pkg::PROD_W'(pp_lo);
    end else if (cmd.mul_hi) begin
      p_r   <= p_r + {pp_hi, 17'd0};
      rem_r <= '0;
    end else if (cmd.div_step) begin
      // restoring division, quotient bits shift into the dividend register
      rem_r <= ge ? 33'(sh - {1'b0, d_r}) : sh[32:0];
      p_r   <= {p_r[plc_pkg::PROD_W-2:0], ge};
    end
  end

  // clamp, add to base, saturate
  logic [40:0]        q_cl;
  logic signed [41:0] base_ext, sum;
  logic signed [31:0] calc_val;
  logic               calc_sat;
  always_comb begin
    q_cl     = (p_r > plc_pkg::PROD_W'(64'h100_0000_0000)) ? 41'h100_0000_0000 : p_r[40:0];
    base_ext = {{10{by_r[31]}}, by_r};
    sum      = neg_r ? base_ext - $signed({1'b0, q_cl}) : base_ext + $signed({1'b0, q_cl});
    calc_sat = 1'b1;
    if (sum > 42'sd2147483647)       calc_val = 32'sh7fff_ffff;
    else if (sum < -42'sd2147483648) calc_val = 32'sh8000_0000;
    else begin
      calc_val = sum[31:0];
      calc_sat = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      case (cmd.res_sel)
        plc_pkg::RES_ZERO:   begin corrected_value <= '0;     status <= plc_pkg::ST_OK;     end
        plc_pkg::RES_REJECT: begin corrected_value <= '0;     status <= plc_pkg::ST_REJECT; end
        plc_pkg::RES_PASS:   begin corrected_value <= m_r;    status <= plc_pkg::ST_PASS;   end
        plc_pkg::RES_FIRST:  begin corrected_value <= real_q; status <= plc_pkg::ST_OK;     end
        plc_pkg::RES_LEFT:   begin corrected_value <= sy0_r;  status <= plc_pkg::ST_DEGEN;  end
        plc_pkg::RES_CALC: begin
          corrected_value <= calc_val;
          status          <= calc_sat ? plc_pkg::ST_SAT : plc_pkg::ST_OK;
        end
        default:             begin corrected_value <= '0;     status <= plc_pkg::ST_REJECT; end
      endcase
    end
  end

endmodule

// ----- rtl/plc_ctrl.sv -----
// Controller: sequences decode, point scan, multiply, divide and result hand-off.
module plc_ctrl #(
  parameter int POINTS = plc_pkg::POINTS_DEF,
  localparam int PIW   = $clog2(POINTS),
  localparam int NW    = $clog2(POINTS + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  plc_pkg::plc_stat_t stat,
  input  logic [NW-1:0]      n_pts,
  output logic [PIW-1:0]     rd_idx,
  output plc_pkg::plc_cmd_t  cmd
);

  plc_pkg::plc_state_t state_r, state_nxt;
  plc_pkg::res_sel_t   res_sel_r, res_sel_nxt;
  logic [PIW-1:0]      k_r, k_nxt;
  logic [plc_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                last;

  assign rd_idx    = k_r;
  assign out_valid = out_valid_r;
  assign in_ready  = (state_r == plc_pkg::S_IDLE);
  assign last      = ((NW'(k_r) + NW'(1)) == n_pts);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= plc_pkg::S_IDLE;
      res_sel_r   <= plc_pkg::RES_ZERO;
      k_r         <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      res_sel_r   <= res_sel_nxt;
      k_r         <= k_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    res_sel_nxt = res_sel_r;
    k_nxt       = k_r;
    cnt_nxt     = cnt_r;
    cmd         = '0;
    cmd.res_sel = res_sel_r;
    case (state_r)
      plc_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = plc_pkg::S_DECODE;
        end
      end
      plc_pkg::S_DECODE: begin
        state_nxt = plc_pkg::S_EMIT;
        k_nxt     = '0;
        if (stat.reject) begin
          res_sel_nxt = plc_pkg::RES_REJECT;
        end else if (stat.func == plc_pkg::FUNC_STORE) begin
          cmd.store_wr = 1'b1;
          res_sel_nxt  = plc_pkg::RES_ZERO;
        end else if (stat.func == plc_pkg::FUNC_COUNT) begin
          cmd.count_wr = 1'b1;
          res_sel_nxt  = plc_pkg::RES_ZERO;
        end else if (stat.n_zero) begin
          res_sel_nxt = plc_pkg::RES_PASS;
        end else begin
          state_nxt = plc_pkg::S_READ;
        end
      end
      plc_pkg::S_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = plc_pkg::S_SCAN;
      end
      plc_pkg::S_SCAN: begin
        cmd.scan        = 1'b1;
        cmd.scan_first  = (k_r == '0);
        cmd.scan_second = (k_r == PIW'(1));
        if (stat.n_one) begin
          res_sel_nxt = plc_pkg::RES_FIRST;
          state_nxt   = plc_pkg::S_EMIT;
        end else if ((k_r != '0) && stat.hit) begin
          cmd.pick_hit = 1'b1;
          state_nxt    = plc_pkg::S_SETUP;
        end else if (last) begin
          cmd.pick_end = 1'b1;
          state_nxt    = plc_pkg::S_SETUP;
        end else begin
          k_nxt     = k_r + PIW'(1);
          state_nxt = plc_pkg::S_READ;
        end
      end
      plc_pkg::S_SETUP: begin
        if (stat.degen) begin
          res_sel_nxt = plc_pkg::RES_LEFT;
          state_nxt   = plc_pkg::S_EMIT;
        end else begin
          cmd.setup = 1'b1;
          state_nxt = plc_pkg::S_MUL_LO;
        end
      end
      plc_pkg::S_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = plc_pkg::S_MUL_HI;
      end
      plc_pkg::S_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        cnt_nxt    = '0;
        state_nxt  = plc_pkg::S_DIV;
      end
      plc_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + plc_pkg::DIV_CNT_W'(1);
        if (cnt_r == plc_pkg::DIV_CNT_W'(plc_pkg::DIV_STEPS - 1)) begin
          res_sel_nxt = plc_pkg::RES_CALC;
          state_nxt   = plc_pkg::S_EMIT;
        end
      end
      plc_pkg::S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = plc_pkg::S_IDLE;
        end
      end
      default: state_nxt = plc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load)     out_valid_nxt = 1'b1;
    else if (out_ready)   out_valid_nxt = 1'b0;
  end

  a_rd_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_en |-> (NW'(k_r) < n_pts))
    else $error("point read beyond channel count");

  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == plc_pkg::S_DIV) |-> (cnt_r < plc_pkg::DIV_CNT_W'(plc_pkg::DIV_STEPS)))
    else $error("divider overran its step count");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result overwrote an untaken beat");

  a_emit_next: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> (out_valid_r && state_r == plc_pkg::S_IDLE))
    else $error("result hand-off did not complete");

endmodule

// ----- rtl/piecewise_linear_calibration_unit.sv -----
// Store/count/reject/passthrough go straight from decode to the result; a single point
// adds one point read, a degenerate segment a scan of up to POINTS points, and a conversion
// that scan plus the split multiply and divider. One item at a time; the point scan (one
// memory read per point) and the one-bit-per-cycle 66-step divider set the rate. A new
// beat is taken while a result waits. Reset (rst_n, synchronous, active low) clears point
// counts and control, not point tables (unknown until written); output stalls add delay.
module piecewise_linear_calibration_unit #(
  parameter int POINTS          = plc_pkg::POINTS_DEF,
  parameter int SINGLE_CHANNELS = plc_pkg::SINGLE_CHANNELS_DEF,
  parameter int DIFF_CHANNELS   = plc_pkg::DIFF_CHANNELS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  plc_in_if.sink    in_ch,
  plc_out_if.source out_ch
);

  // single-ended channels first, then differential, one shared index
  localparam int CHANNELS = SINGLE_CHANNELS + DIFF_CHANNELS;
  localparam int PIW      = $clog2(POINTS);
  localparam int NW       = $clog2(POINTS + 1);

  plc_pkg::plc_cmd_t  cmd;
  plc_pkg::plc_stat_t stat;
  logic [PIW-1:0]     rd_idx;
  logic [NW-1:0]      n_pts;

  // controller: owns the handshakes, scan index and divide counter
  plc_ctrl #(.POINTS(POINTS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .n_pts     (n_pts),
    .rd_idx    (rd_idx),
    .cmd       (cmd)
  );

  // datapath: tables, search registers, split multiply, divider, saturation, result beat
  plc_datapath #(.POINTS(POINTS), .CHANNELS(CHANNELS)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .rd_idx          (rd_idx),
    .stat            (stat),
    .n_pts           (n_pts),
    .func            (in_ch.func),
    .channel_index   (in_ch.channel_index),
    .point_index     (in_ch.point_index),
    .raw_value       (in_ch.raw_value),
    .real_value      (in_ch.real_value),
    .point_total     (in_ch.point_total),
    .measured_value  (in_ch.measured_value),
    .corrected_value (out_ch.corrected_value),
    .status          (out_ch.status)
  );

endmodule

// ----- dv/piecewise_linear_calibration_unit_tb.sv -----
// Self-checking testbench for the piecewise-linear calibration unit.
module piecewise_linear_calibration_unit_tb;
  import plc_pkg::*;

  localparam int NCH        = SINGLE_CHANNELS_DEF + DIFF_CHANNELS_DEF;
  localparam int NPT        = POINTS_DEF;
  localparam int IDLE_LIMIT = 4000;   // cycles with no beat on either side
  localparam int SETTLE     = 120;    // > longest conversion latency
  localparam int RAND_ITEMS = 1330;
  localparam int CALM_ITEMS = 150;    // final stretch without idling

  typedef struct packed {
    logic [FUNC_W-1:0]         func;
    logic [CH_W-1:0]           ch;
    logic [PT_W-1:0]           pt;
    logic signed [DATA_W-1:0]  raw;
    logic signed [DATA_W-1:0]  real_v;
    logic [TOTAL_W-1:0]        total;
    logic signed [DATA_W-1:0]  meas;
  } cal_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]  value;
    logic [STATUS_W-1:0]       status;
  } cal_result_t;

  logic clk;
  logic rst_n;

  plc_in_if  in_ch ();
  plc_out_if out_ch ();

  piecewise_linear_calibration_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Shadow calibration tables
  logic signed [DATA_W-1:0] raw_tbl  [NCH][NPT];
  logic signed [DATA_W-1:0] real_tbl [NCH][NPT];
  logic [TOTAL_W-1:0]       cnt_tbl  [NCH];
  bit                       written  [NCH][NPT];

  cal_result_t expected_q[$];
  int  mismatches = 0;
  int  sent       = 0;
  bit  calm       = 0;   // no idling on either side
  int  quiet_cycles = 0;

  // ---------------------------------------------------------------------------
  // Clock and watchdog
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (rst_n) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  // base + trunc(dx*dy/dd), quotient magnitude capped at 2^40
  function automatic longint seg_interp(longint base, longint dx, longint dy, longint dd);
    logic [65:0] ua, ub, ud, prod, quo;
    bit neg;
    ua   = 66'(dx < 0 ? -dx : dx);
    ub   = 66'(dy < 0 ? -dy : dy);
    ud   = 66'(dd < 0 ? -dd : dd);
    neg  = ((dx < 0) != (dy < 0)) != (dd < 0);
    prod = ua * ub;
    quo  = prod / ud;
    if (quo > (66'd1 << 40)) quo = 66'd1 << 40;
    return neg ? base - longint'(quo) : base + longint'(quo);
  endfunction

  function automatic cal_result_t convert_meas(int c, longint m);
    cal_result_t r;
    int n, k;
    longint v;
    bit hit;
    n   = cnt_tbl[c];
    hit = 0;
    k   = 0;
    r.status = ST_OK;
    if (n == 0) begin
      r.value  = DATA_W'(m);
      r.status = ST_PASS;
      return r;
    end
    if (n == 1) begin
      r.value = real_tbl[c][0];
      return r;
    end
    for (int i = 0; i + 1 < n; i++) begin
      if (!hit && m >= raw_tbl[c][i] && m <= raw_tbl[c][i+1]) begin
        hit = 1;
        k   = i;
      end
    end
    if (!hit) k = (m < raw_tbl[c][0]) ? 0 : n - 2;
    if (raw_tbl[c][k+1] == raw_tbl[c][k]) begin
      r.value  = real_tbl[c][k];
      r.status = ST_DEGEN;
      return r;
    end
    if (hit || m < raw_tbl[c][0])
      v = seg_interp(real_tbl[c][k], m - raw_tbl[c][k],
                     longint'(real_tbl[c][k+1]) - real_tbl[c][k],
                     longint'(raw_tbl[c][k+1]) - raw_tbl[c][k]);
    else
      v = seg_interp(real_tbl[c][k+1], m - raw_tbl[c][k+1],
                     longint'(real_tbl[c][k+1]) - real_tbl[c][k],
                     longint'(raw_tbl[c][k+1]) - raw_tbl[c][k]);
    if (!hit && v > 64'sd2147483647) begin
      v = 64'sd2147483647;
      r.status = ST_SAT;
    end else if (!hit && v < -64'sd2147483648) begin
      v = -64'sd2147483648;
      r.status = ST_SAT;
    end
    r.value = DATA_W'(v);
    return r;
  endfunction

  function automatic cal_result_t calibrate(cal_item_t it);
    cal_result_t r;
    r.value  = '0;
    r.status = ST_OK;
    if (it.ch >= NCH || it.func == FUNC_BAD) begin
      r.status = ST_REJECT;
    end else if (it.func == FUNC_STORE) begin
      if (it.pt >= NPT) begin
        r.status = ST_REJECT;
      end else begin
        raw_tbl[it.ch][it.pt]  = it.raw;
        real_tbl[it.ch][it.pt] = it.real_v;
        written[it.ch][it.pt]  = 1;
      end
    end else if (it.func == FUNC_COUNT) begin
      if (it.total > NPT) r.status = ST_REJECT;
      else cnt_tbl[it.ch] = it.total;
    end else begin
      r = convert_meas(it.ch, longint'(it.meas));
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker and sink-side stalls
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    cal_result_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result value=%0d status=%0d",
                   out_ch.corrected_value, out_ch.status);
      end else begin
        exp_r = expected_q.pop_front();
        if (out_ch.corrected_value !== exp_r.value || out_ch.status !== exp_r.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: result mismatch exp value=%0d status=%0d, got value=%0d status=%0d",
                     exp_r.value, exp_r.status, out_ch.corrected_value, out_ch.status);
        end
      end
    end
  end

  initial begin
    int stall;
    stall = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        stall--;
        out_ch.ready = 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 4) - 1;
        out_ch.ready = 1'b0;
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: one beat per call, optional idle burst first
  // ---------------------------------------------------------------------------
  task automatic send_item(cal_item_t it);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_ch.valid          = 1'b1;
    in_ch.func           = it.func;
    in_ch.channel_index  = it.ch;
    in_ch.point_index    = it.pt;
    in_ch.raw_value      = it.raw;
    in_ch.real_value     = it.real_v;
    in_ch.point_total    = it.total;
    in_ch.measured_value = it.meas;
    do @(posedge clk); while (!in_ch.ready);
    expected_q.push_back(calibrate(it));
    sent++;
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  function automatic cal_item_t mk_item(logic [FUNC_W-1:0] f, int c);
    cal_item_t it;
    it.func   = f;
    it.ch     = CH_W'(c);
    it.pt     = PT_W'($urandom);
    it.raw    = $urandom;
    it.real_v = $urandom;
    it.total  = TOTAL_W'($urandom);
    it.meas   = $urandom;
    return it;
  endfunction

  task automatic store_pt(int c, int p, int x, int y);
    cal_item_t it;
    it = mk_item(FUNC_STORE, c);
    it.pt = PT_W'(p);
    it.raw = x;
    it.real_v = y;
    send_item(it);
  endtask

  task automatic set_count(int c, int n);
    cal_item_t it;
    it = mk_item(FUNC_COUNT, c);
    it.total = TOTAL_W'(n);
    send_item(it);
  endtask

  task automatic convert_at(int c, int m);
    cal_item_t it;
    it = mk_item(FUNC_CONVERT, c);
    it.meas = m;
    send_item(it);
  endtask

  // largest n such that points 0..n-1 of channel c are stored
  function automatic int stored_prefix(int c);
    int n;
    n = 0;
    while (n < NPT && written[c][n]) n++;
    return n;
  endfunction

  task automatic wait_drained();
    while (expected_q.size() != 0) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed();
    cal_item_t it;
    // empty tables pass extremes straight through
    convert_at(0, 32'sh7fffffff);
    convert_at(NCH - 1, 32'sh80000000);
    // rejects: bad channels, func 3, oversize count
    it = mk_item(FUNC_CONVERT, 7);
    send_item(it);
    it = mk_item(FUNC_STORE, 6);
    send_item(it);
    it = mk_item(FUNC_BAD, 1);
    send_item(it);
    set_count(2, 15);
    set_count(2, 9);
    // single point returns its real value
    store_pt(1, 0, 32'sh00010000, 32'sh7fffffff);
    set_count(1, 1);
    convert_at(1, 32'sh80000000);
    // two points: inside, below, above, saturation both ways
    store_pt(2, 0, -32'sh00010000, -32'sh00020000);
    store_pt(2, 1, 32'sh00010000, 32'sh00020000);
    set_count(2, 2);
    convert_at(2, 32'sh00008000);
    convert_at(2, 32'sh80000000);
    convert_at(2, 32'sh7fffffff);
    // degenerate segment, then a descending one with top point index
    store_pt(3, 0, 32'sh00050000, 32'sh00001000);
    store_pt(3, 1, 32'sh00050000, 32'sh00002000);
    set_count(3, 2);
    convert_at(3, 32'sh00050000);
    store_pt(3, 2, 32'sh80000000, 32'sh7fffffff);
    store_pt(3, 1, 32'sh7fffffff, 32'sh80000000);
    for (int p = 3; p < NPT; p++) store_pt(3, p, -32'sh00100000 * p, 32'sh00001000 * p);
    set_count(3, NPT);
    convert_at(3, 32'sh00060000);
    convert_at(3, 32'sh80000000);
    set_count(3, 0);
    convert_at(3, 32'sh12345678);
  endtask

  function automatic int pick_value(int mode, int p);
    case (mode)
      0: return p * 32'sh00020000 + $urandom_range(0, 32'h0001ffff);  // ascending
      1: return -p * 32'sh00030000 + $urandom_range(0, 1000);          // descending
      2: return $urandom_range(0, 3) - 1;                              // tiny, repeats
      default: return $urandom;                                        // anywhere
    endcase
  endfunction

  task automatic random_session();
    int c, n, mode, nconv, m, r;
    cal_item_t it;
    if ($urandom_range(0, 6) == 0) begin
      // noise: any function, channel and fields, never enabling unstored points
      it = mk_item(FUNC_W'($urandom), $urandom_range(0, 7));
      if (it.func == FUNC_COUNT && it.ch < NCH && it.total <= NPT &&
          it.total > stored_prefix(it.ch))
        it.total = TOTAL_W'(stored_prefix(it.ch));
      send_item(it);
      return;
    end
    c    = $urandom_range(0, NCH - 1);
    n    = ($urandom_range(0, 4) == 0) ? NPT : $urandom_range(0, NPT);
    mode = $urandom_range(0, 3);
    for (int p = 0; p < n; p++)
      store_pt(c, p, pick_value(mode, p), $urandom_range(0, 1) ? int'($urandom)
               : pick_value(mode, p) >>> 1);
    if (n > stored_prefix(c)) n = stored_prefix(c);
    set_count(c, n);
    nconv = $urandom_range(1, 6);
    for (int j = 0; j < nconv; j++) begin
      r = $urandom_range(0, 5);
      if (n > 0 && r < 3) m = raw_tbl[c][$urandom_range(0, n - 1)] + $urandom_range(0, 8) - 4;
      else if (r == 3) m = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      else m = $urandom;
      convert_at(c, m);
    end
  endtask

  task automatic test_random();
    int stop;
    stop = sent + RAND_ITEMS - CALM_ITEMS;
    while (sent < stop) random_session();
  endtask

  task automatic test_drained_restart();
    // sender holds off until every result is back, then resumes
    wait_drained();
    repeat (SETTLE) @(negedge clk);
    convert_at(0, $urandom);
    random_session();
  endtask

  task automatic test_back_to_back();
    int stop;
    calm = 1;
    stop = sent + CALM_ITEMS;
    while (sent < stop) random_session();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    for (int c = 0; c < NCH; c++) begin
      cnt_tbl[c] = '0;
      for (int p = 0; p < NPT; p++) begin
        raw_tbl[c][p]  = '0;
        real_tbl[c][p] = '0;
        written[c][p]  = 0;
      end
    end
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.func           = FUNC_STORE;
    in_ch.channel_index  = '0;
    in_ch.point_index    = '0;
    in_ch.raw_value      = '0;
    in_ch.real_value     = '0;
    in_ch.point_total    = '0;
    in_ch.measured_value = '0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed();
    test_drained_restart();
    test_random();
    test_back_to_back();

    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
